// ===== rtl/subgraph_node_reindexer_defines.svh =====
// Assertion macros for the subgraph node reindexer.
// Relies on clk and rst_n being visible in the including scope.
`ifndef SUBGRAPH_NODE_REINDEXER_DEFINES_SVH
`define SUBGRAPH_NODE_REINDEXER_DEFINES_SVH

// same-cycle implication
`define SNR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SNR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/snr_pkg.sv =====
// Shared types and constants for the subgraph node reindexer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package snr_pkg;
  localparam int LOCAL_W = 12;
  localparam int OUT_VERTEX_W = 48;
  localparam int HASH_SHIFT = 20;
  localparam logic [63:0] HASH_MULT = 64'h9E3779B97F4A7C15;

  typedef enum logic [1:0] {
    REQ_SEED  = 2'd0,
    REQ_NBR   = 2'd1,
    REQ_START = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_UNKNOWN = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_START,
    S_PROBE,
    S_CMP
  } state_t;
endpackage
`default_nettype wire

// ===== rtl/snr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module snr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/snr_hash.sv =====
// Multiplicative hash: key * golden constant, bits above HASH_SHIFT give the slot.
// Two partial products registered, summed in the next cycle. Uses snr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module snr_hash #(
  parameter int KEY_W  = 48,
  parameter int ADDR_W = 12
) (
  input  wire logic              clk,
  input  wire logic [KEY_W-1:0]  key,
  output logic      [ADDR_W-1:0] slot
);
  import snr_pkg::*;

  localparam int P  = HASH_SHIFT + ADDR_W;
  localparam int H  = P / 2;
  localparam int PH = P - H;

  logic [P-1:0]  key_p;
  logic [P-1:0]  mult_p;
  logic [P-1:0]  pp0_r;
  logic [PH-1:0] pp1_r;
  logic [P-1:0]  sum;

  assign key_p  = P'(key);
  assign mult_p = HASH_MULT[P-1:0];

  always_ff @(posedge clk) begin
    pp0_r <= P'(key_p[H-1:0] * mult_p);
    pp1_r <= PH'(key_p[P-1:H] * mult_p[PH-1:0]);
  end

  assign sum  = pp0_r + {pp1_r, {H{1'b0}}};
  assign slot = sum[P-1:HASH_SHIFT];
endmodule
`default_nettype wire

// ===== rtl/subgraph_node_reindexer.sv =====
// Subgraph node reindexer: hash map from global vertex to dense local id.
// Uses snr_pkg, snr_hash, snr_ram and subgraph_node_reindexer_defines.svh.
//
// Channels: in_* (req_type, vertex, seed_vertex) and out_* results, both
// valid/ready; a transfer happens when valid and ready are both high.
// Seed and neighbor items give one result; start and unused items give none.
// The table is one RAM of {valid, key, id} probed linearly from the hash slot.
// Steps: hash, home slot read, compare, plus a further read and compare per
// further probe step; a neighbor runs one lookup for its seed vertex and then
// one for its vertex. One item at a time; the next item is taken only once the
// block is back in idle after the result is loaded. A new item is taken once
// the output register is free or draining, so a stalled receiver holds the
// result and blocks input.
// Reset and start items run a clearing pass over every RAM entry; no item is
// taken during it. TABLE_ENTRIES must be a power of two.
// Status 1 flags a full table or id space, status 2 an unknown seed.
`timescale 1ns / 1ps
`default_nettype none
module subgraph_node_reindexer #(
  parameter int TABLE_ENTRIES = 4096,
  parameter int VERTEX_BITS   = 48
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [1:0]                        in_req_type,
  input  wire logic [VERTEX_BITS-1:0]            in_vertex,
  input  wire logic [VERTEX_BITS-1:0]            in_seed_vertex,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_frontier_valid,
  output logic [snr_pkg::OUT_VERTEX_W-1:0]       out_frontier_vertex,
  output logic [snr_pkg::LOCAL_W-1:0]            out_frontier_local,
  output logic                                   out_edge_valid,
  output logic [snr_pkg::LOCAL_W-1:0]            out_edge_row,
  output logic [snr_pkg::LOCAL_W-1:0]            out_edge_col,
  output logic [1:0]                             out_status
);
  import snr_pkg::*;
  `include "subgraph_node_reindexer_defines.svh"

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int DW = 1 + VERTEX_BITS + AW;

  state_t state_r, state_nxt;
  req_t type_r, type_nxt;
  logic [VERTEX_BITS-1:0] v_r, v_nxt, sv_r, sv_nxt;
  logic phase_r, phase_nxt;
  logic [AW-1:0] addr_r, addr_nxt, cnt_r, cnt_nxt, row_r, row_nxt;
  logic [AW:0] next_local_r, next_local_nxt;

  logic ov_r, ov_nxt, ofv_r, ofv_nxt, oev_r, oev_nxt;
  logic [OUT_VERTEX_W-1:0] ofvert_r, ofvert_nxt;
  logic [LOCAL_W-1:0] oflocal_r, oflocal_nxt, orow_r, orow_nxt, ocol_r, ocol_nxt;
  status_t ost_r, ost_nxt;

  logic [VERTEX_BITS-1:0] key_sel;
  logic [AW-1:0] hash_slot, raddr, waddr;
  logic we;
  logic [DW-1:0] wdata, rdata;
  logic r_valid, empty, hit, last, full;
  logic [VERTEX_BITS-1:0] r_key;
  logic [AW-1:0] r_id;

  assign key_sel = (type_r == REQ_NBR && !phase_r) ? sv_r : v_r;

  snr_hash #(.KEY_W(VERTEX_BITS), .ADDR_W(AW)) u_hash (
    .clk  (clk),
    .key  (key_sel),
    .slot (hash_slot)
  );

  snr_ram #(.WIDTH(DW), .DEPTH(TABLE_ENTRIES)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign raddr   = (state_r == S_START) ? hash_slot : addr_r;
  assign r_valid = rdata[DW-1];
  assign r_key   = rdata[DW-2:AW];
  assign r_id    = rdata[AW-1:0];
  assign empty   = !r_valid;
  assign hit     = r_valid && (r_key == v_r || (type_r == REQ_NBR && !phase_r))
                   && r_key == key_sel;
  assign last    = &cnt_r;
  assign full    = next_local_r[AW];

  assign in_ready = (state_r == S_IDLE) && (!ov_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      next_local_r <= '0;
      addr_r       <= '0;
      ov_r         <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      next_local_r <= next_local_nxt;
      addr_r       <= addr_nxt;
      ov_r         <= ov_nxt;
    end
    type_r    <= type_nxt;
    v_r       <= v_nxt;
    sv_r      <= sv_nxt;
    phase_r   <= phase_nxt;
    cnt_r     <= cnt_nxt;
    row_r     <= row_nxt;
    ofv_r     <= ofv_nxt;
    ofvert_r  <= ofvert_nxt;
    oflocal_r <= oflocal_nxt;
    oev_r     <= oev_nxt;
    orow_r    <= orow_nxt;
    ocol_r    <= ocol_nxt;
    ost_r     <= ost_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    type_nxt       = type_r;
    v_nxt          = v_r;
    sv_nxt         = sv_r;
    phase_nxt      = phase_r;
    addr_nxt       = addr_r;
    cnt_nxt        = cnt_r;
    row_nxt        = row_r;
    next_local_nxt = next_local_r;
    ov_nxt         = ov_r && !out_ready;
    ofv_nxt        = ofv_r;
    ofvert_nxt     = ofvert_r;
    oflocal_nxt    = oflocal_r;
    oev_nxt        = oev_r;
    orow_nxt       = orow_r;
    ocol_nxt       = ocol_r;
    ost_nxt        = ost_r;
    we             = 1'b0;
    waddr          = addr_r;
    wdata          = {1'b1, v_r, next_local_r[AW-1:0]};

    case (state_r)
      S_CLEAR: begin
        we       = 1'b1;
        wdata    = '0;
        addr_nxt = addr_r + 1'b1;
        if (&addr_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          type_nxt  = req_t'(in_req_type);
          v_nxt     = in_vertex;
          sv_nxt    = in_seed_vertex;
          phase_nxt = 1'b0;
          case (req_t'(in_req_type))
            REQ_SEED, REQ_NBR: state_nxt = S_HASH;
            REQ_START: begin
              next_local_nxt = '0;
              addr_nxt       = '0;
              state_nxt      = S_CLEAR;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_HASH: state_nxt = S_START;
      S_START: begin
        addr_nxt  = hash_slot;
        cnt_nxt   = '0;
        state_nxt = S_CMP;
      end
      S_PROBE: state_nxt = S_CMP;
      S_CMP: begin
        if (!empty && !hit && !last) begin
          addr_nxt  = addr_r + 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_PROBE;
        end else if (type_r == REQ_NBR && !phase_r) begin
          if (hit) begin
            row_nxt   = r_id;
            phase_nxt = 1'b1;
            state_nxt = S_HASH;
          end else begin
            ov_nxt    = 1'b1;
            ofv_nxt   = 1'b0;
            oev_nxt   = 1'b0;
            ofvert_nxt = '0;
            oflocal_nxt = '0;
            orow_nxt  = '0;
            ocol_nxt  = '0;
            ost_nxt   = ST_UNKNOWN;
            state_nxt = S_IDLE;
          end
        end else begin
          ov_nxt      = 1'b1;
          state_nxt   = S_IDLE;
          ofv_nxt     = 1'b0;
          oev_nxt     = 1'b0;
          ofvert_nxt  = '0;
          oflocal_nxt = '0;
          orow_nxt    = '0;
          ocol_nxt    = '0;
          ost_nxt     = ST_OK;
          if (type_r == REQ_NBR && hit) begin
            oev_nxt  = 1'b1;
            orow_nxt = LOCAL_W'(row_r);
            ocol_nxt = LOCAL_W'(r_id);
          end else if ((!empty && !hit) || full) begin
            ost_nxt = ST_FULL;
          end else begin
            we             = 1'b1;
            next_local_nxt = next_local_r + 1'b1;
            ofv_nxt        = 1'b1;
            ofvert_nxt     = OUT_VERTEX_W'(v_r);
            oflocal_nxt    = LOCAL_W'(next_local_r[AW-1:0]);
            if (type_r == REQ_NBR) begin
              oev_nxt  = 1'b1;
              orow_nxt = LOCAL_W'(row_r);
              ocol_nxt = LOCAL_W'(next_local_r[AW-1:0]);
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid           = ov_r;
  assign out_frontier_valid  = ofv_r;
  assign out_frontier_vertex = ofvert_r;
  assign out_frontier_local  = oflocal_r;
  assign out_edge_valid      = oev_r;
  assign out_edge_row        = orow_r;
  assign out_edge_col        = ocol_r;
  assign out_status          = ost_r;

  `SNR_ASSERT_IMPL(a_front_ok, out_valid && out_frontier_valid,
    out_status == ST_OK, "frontier with bad status")
  `SNR_ASSERT_IMPL(a_err_quiet, out_valid && out_status != ST_OK,
    !out_frontier_valid && !out_edge_valid, "error result carries data")
  `SNR_ASSERT_NEXT(a_start_clr, in_valid && in_ready && in_req_type == REQ_START,
    next_local_r == '0 && state_r == S_CLEAR, "start did not clear")
  `SNR_ASSERT_IMPL(a_id_bound, state_r == S_CMP && we, !full,
    "id handed out past table size")
endmodule
`default_nettype wire

// ===== sim/tb_subgraph_node_reindexer.sv =====
// Self-checking testbench for subgraph_node_reindexer: directed and random transfers
// are scored against a hash-map relabel predictor held in a scoreboard class.
// Depends on snr_pkg and the RTL of the block only.
`timescale 1ns / 1ps
module tb_subgraph_node_reindexer;
  import snr_pkg::*;

  localparam int SLOTS = 4096;
  localparam int VW = 48;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic          fv;
    logic [VW-1:0] fvert;
    logic [11:0]   floc;
    logic          ev;
    logic [11:0]   row;
    logic [11:0]   col;
    logic [1:0]    status;
  } relabel_t;

  class relabel_board;
    logic [VW-1:0] keys [SLOTS];
    logic [11:0]   ids [SLOTS];
    bit            used [SLOTS];
    int            next_id;
    relabel_t      pending_q[$];
    int            errors;

    function new();
      clear();
      errors = 0;
    endfunction

    function void clear();
      foreach (used[i]) used[i] = 0;
      next_id = 0;
    endfunction

    // linear probe from the hashed slot; -1 when every slot is taken by others
    function int find_slot(logic [VW-1:0] key, output bit hit);
      logic [63:0] prod;
      int slot;
      prod = {16'd0, key} * HASH_MULT;
      slot = int'(prod[HASH_SHIFT +: 12]);
      hit = 0;
      for (int i = 0; i < SLOTS; i++) begin
        if (!used[slot]) return slot;
        if (keys[slot] == key) begin
          hit = 1;
          return slot;
        end
        slot = (slot + 1) % SLOTS;
      end
      return -1;
    endfunction

    function void insert(int slot, logic [VW-1:0] key);
      keys[slot] = key;
      ids[slot] = next_id[11:0];
      used[slot] = 1;
      next_id++;
    endfunction

    function void note(logic [1:0] kind, logic [VW-1:0] v, logic [VW-1:0] sv);
      relabel_t r;
      bit hit;
      int s;
      logic [11:0] row;
      r = '0;
      case (kind)
        REQ_START: begin
          clear();
          return;
        end
        REQ_NONE: return;
        REQ_SEED: begin
          s = find_slot(v, hit);
          if (s < 0 || next_id >= SLOTS) r.status = ST_FULL;
          else begin
            r.fv = 1;
            r.fvert = v;
            r.floc = next_id[11:0];
            insert(s, v);
          end
        end
        default: begin
          s = find_slot(sv, hit);
          if (s < 0 || !hit) r.status = ST_UNKNOWN;
          else begin
            row = ids[s];
            s = find_slot(v, hit);
            if (s >= 0 && hit) r.col = ids[s];
            else if (s < 0 || next_id >= SLOTS) r.status = ST_FULL;
            else begin
              r.fv = 1;
              r.fvert = v;
              r.floc = next_id[11:0];
              r.col = next_id[11:0];
              insert(s, v);
            end
            if (r.status == ST_OK) begin
              r.ev = 1;
              r.row = row;
            end
          end
        end
      endcase
      pending_q = {pending_q, r};
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check(relabel_t got);
      relabel_t w;
      if (pending_q.size() == 0) begin
        report("unexpected result", 64'(got), 64'd0);
        return;
      end
      w = pending_q.pop_front();
      if (got.fv !== w.fv) report("frontier_valid", 64'(got.fv), 64'(w.fv));
      if (got.fvert !== w.fvert) report("frontier_vertex", 64'(got.fvert), 64'(w.fvert));
      if (got.floc !== w.floc) report("frontier_local", 64'(got.floc), 64'(w.floc));
      if (got.ev !== w.ev) report("edge_valid", 64'(got.ev), 64'(w.ev));
      if (got.row !== w.row) report("edge_row", 64'(got.row), 64'(w.row));
      if (got.col !== w.col) report("edge_col", 64'(got.col), 64'(w.col));
      if (got.status !== w.status) report("status", 64'(got.status), 64'(w.status));
    endtask
  endclass

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  logic [1:0]    in_req_type;
  logic [VW-1:0] in_vertex;
  logic [VW-1:0] in_seed_vertex;
  logic          out_valid;
  logic          out_ready;
  relabel_t      got;
  int            send_idle_pct;
  int            recv_stall_pct;
  int            cycles;
  logic [VW-1:0] vpool [64];
  relabel_board  sb;

  subgraph_node_reindexer i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_vertex          (in_vertex),
    .in_seed_vertex     (in_seed_vertex),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_frontier_valid (got.fv),
    .out_frontier_vertex(got.fvert),
    .out_frontier_local (got.floc),
    .out_edge_valid     (got.ev),
    .out_edge_row       (got.row),
    .out_edge_col       (got.col),
    .out_status         (got.status)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note(in_req_type, in_vertex, in_seed_vertex);
      if (out_valid && out_ready) sb.check(got);
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [VW-1:0] rand_vertex();
    return VW'({$urandom(), $urandom()});
  endfunction

  task automatic send(logic [1:0] kind, logic [VW-1:0] v, logic [VW-1:0] sv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    in_req_type = kind;
    in_vertex = v;
    in_seed_vertex = sv;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic drain();
    in_valid = 0;
    while (sb.pending_q.size() != 0) @(negedge clk);
  endtask

  task automatic refill_pool();
    foreach (vpool[i]) vpool[i] = rand_vertex();
    vpool[0] = '0;
    vpool[1] = '1;
  endtask

  task automatic random_items(int count);
    int pick;
    logic [VW-1:0] a;
    logic [VW-1:0] b;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      a = vpool[6'($urandom_range(63))];
      b = vpool[6'($urandom_range(63))];
      if (pick < 1) begin
        send(REQ_START, rand_vertex(), rand_vertex());
        refill_pool();
      end else if (pick < 3) send(REQ_NONE, rand_vertex(), rand_vertex());
      else if (pick < 28) send(REQ_SEED, a, rand_vertex());
      else if (pick < 33) send(REQ_NBR, a, rand_vertex());
      else if (pick < 38) send(REQ_NBR, rand_vertex(), b);
      else send(REQ_NBR, a, b);
    end
  endtask

  initial begin
    sb = new();
    cycles = 0;
    rst_n = 0;
    in_valid = 0;
    in_req_type = REQ_NONE;
    in_vertex = '0;
    in_seed_vertex = '0;
    out_ready = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    refill_pool();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    send(REQ_SEED, '0, '1);
    send(REQ_SEED, '1, '0);
    send(REQ_NBR, '1, '0);
    send(REQ_NBR, 48'h5555_AAAA_5555, '0);
    send(REQ_NBR, '0, 48'h1234_5678_9ABC);
    send(REQ_SEED, '0, '0);
    send(REQ_NBR, 48'h5555_AAAA_5555, '0);
    send(REQ_NONE, '1, '1);
    send(REQ_START, '0, '0);
    send(REQ_NBR, '1, '0);
    send(REQ_SEED, 48'hAAAA_5555_AAAA, '0);
    send(REQ_NBR, '0, 48'hAAAA_5555_AAAA);

    random_items(475);
    send_idle_pct = 45;
    random_items(240);
    drain();
    random_items(235);
    send_idle_pct = 0;
    recv_stall_pct = 45;
    random_items(475);
    send_idle_pct = 29;
    recv_stall_pct = 29;
    random_items(475);
    send_idle_pct = 0;
    recv_stall_pct = 0;

    drain();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
